// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Each macro samples on the rising edge
// of clock and is switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold in the cycle where ante holds.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Constants, codes and controller/datapath interface types of the
// fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

   // Pool geometry
   localparam int BLOCK_SLOTS = 512;
   localparam int NUM_BLOCKS  = 8;
   localparam int SLOT_W      = 12;
   localparam int LINK_W      = SLOT_W + 1;
   localparam int SLOT_SPACE  = 1 << SLOT_W;
   localparam int LIST_END    = SLOT_SPACE;
   localparam int CARVED_W    = 4;
   // Blocks that fit both the block count and the index space
   localparam int MAX_BLOCKS  = (NUM_BLOCKS < (SLOT_SPACE / BLOCK_SLOTS)) ?
                                NUM_BLOCKS : (SLOT_SPACE / BLOCK_SLOTS);

   // Request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL = 2'd2;

   // Operation chosen when a transaction is accepted
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_POP   = 3'd0;
   localparam logic [OP_W-1:0] OP_CARVE = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
   localparam logic [OP_W-1:0] OP_NULL  = 3'd3;
   localparam logic [OP_W-1:0] OP_OOM   = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic            start;
      logic [OP_W-1:0] op;
      logic            pop_load;
      logic            carve_step;
      logic            out_load;
      logic            out_direct;
   } fsa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic list_empty;
      logic can_carve;
      logic carve_done;
      logic out_free;
   } fsa_stat_type;

endpackage

// ===== hdl/fsa_datapath.sv =====
// ----------------------------------------------------------------------------
// fsa_datapath
// Link memory, free-list head, carve counter and walk pointer, result
// holding registers and the output register of the allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsa_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fsa_pkg::SLOT_W-1:0]      req_free_slot,
   input  fsa_pkg::fsa_cmd_type            cmd,
   output fsa_pkg::fsa_stat_type           stat,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [fsa_pkg::SLOT_W-1:0]      rsp_alloc_slot,
   output logic [fsa_pkg::STATUS_W-1:0]    rsp_status
);

   // Link memory, one entry per slot
   logic [fsa_pkg::LINK_W-1:0]   link_mem_ff [0:fsa_pkg::SLOT_SPACE-1];
   logic [fsa_pkg::LINK_W-1:0]   rd_data_ff;
   logic                         mem_we;
   logic [fsa_pkg::SLOT_W-1:0]   mem_waddr;
   logic [fsa_pkg::LINK_W-1:0]   mem_wdata;

   logic [fsa_pkg::LINK_W-1:0]   head_ff, head_in;
   logic [fsa_pkg::CARVED_W-1:0] carved_ff, carved_in;
   logic [fsa_pkg::SLOT_W-1:0]   carve_ptr_ff, carve_ptr_in;
   logic [fsa_pkg::SLOT_W-1:0]   carve_last_ff, carve_last_in;
   logic [fsa_pkg::SLOT_W-1:0]   hold_slot_ff, hold_slot_in;
   logic [fsa_pkg::STATUS_W-1:0] hold_status_ff, hold_status_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fsa_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [fsa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [fsa_pkg::SLOT_W-1:0]   block_base;
   logic [fsa_pkg::STATUS_W-1:0] direct_status;
   logic                         out_free;

   // First slot of the next uncarved block
   assign block_base = fsa_pkg::SLOT_W'(32'(carved_ff) * 32'(fsa_pkg::BLOCK_SLOTS));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Status towards the controller
   assign stat.list_empty = head_ff[fsa_pkg::LINK_W-1];
   assign stat.can_carve  = 32'(carved_ff) < 32'(fsa_pkg::MAX_BLOCKS);
   assign stat.carve_done = carve_ptr_ff == carve_last_ff;
   assign stat.out_free   = out_free;

   // Status of a transaction that completes on acceptance
   always_comb begin
      case (cmd.op)
         fsa_pkg::OP_NULL: direct_status = fsa_pkg::STATUS_NULL;
         fsa_pkg::OP_OOM:  direct_status = fsa_pkg::STATUS_OOM;
         default:          direct_status = fsa_pkg::STATUS_DONE;
      endcase
   end

   // Select the link memory write: push on free, chain on carve
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      if (cmd.start && (cmd.op == fsa_pkg::OP_FREE)) begin
         mem_we    = 1'b1;
         mem_waddr = req_free_slot;
         mem_wdata = head_ff;
      end else if (cmd.carve_step) begin
         mem_we    = 1'b1;
         mem_waddr = carve_ptr_ff;
         mem_wdata = stat.carve_done ? fsa_pkg::LINK_W'(fsa_pkg::LIST_END)
                                     : {1'b0, carve_ptr_ff} + fsa_pkg::LINK_W'(1);
      end
   end

   // Write the link memory and register the read of the head entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.start) begin
         rd_data_ff <= link_mem_ff[head_ff[fsa_pkg::SLOT_W-1:0]];
      end
   end

   // Update list head, carve state and held result
   always_comb begin
      head_in        = head_ff;
      carved_in      = carved_ff;
      carve_ptr_in   = carve_ptr_ff;
      carve_last_in  = carve_last_ff;
      hold_slot_in   = hold_slot_ff;
      hold_status_in = hold_status_ff;
      if (cmd.start) begin
         hold_slot_in   = '0;
         hold_status_in = direct_status;
         case (cmd.op)
            fsa_pkg::OP_POP: begin
               hold_slot_in = head_ff[fsa_pkg::SLOT_W-1:0];
            end
            fsa_pkg::OP_CARVE: begin
               hold_slot_in  = block_base;
               head_in       = {1'b0, block_base} + fsa_pkg::LINK_W'(1);
               carved_in     = carved_ff + fsa_pkg::CARVED_W'(1);
               carve_ptr_in  = block_base + fsa_pkg::SLOT_W'(1);
               carve_last_in = block_base + fsa_pkg::SLOT_W'(fsa_pkg::BLOCK_SLOTS - 1);
            end
            fsa_pkg::OP_FREE: begin
               head_in = {1'b0, req_free_slot};
            end
            default: begin
            end
         endcase
      end
      if (cmd.pop_load) begin
         head_in = rd_data_ff;
      end
      if (cmd.carve_step) begin
         carve_ptr_in = carve_ptr_ff + fsa_pkg::SLOT_W'(1);
      end
   end

   // Load or drain the output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (cmd.out_direct) begin
            rsp_slot_in   = '0;
            rsp_status_in = direct_status;
         end else begin
            rsp_slot_in   = hold_slot_ff;
            rsp_status_in = hold_status_ff;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= fsa_pkg::LINK_W'(fsa_pkg::LIST_END);
         carved_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         carved_ff    <= carved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      carve_ptr_ff   <= carve_ptr_in;
      carve_last_ff  <= carve_last_in;
      hold_slot_ff   <= hold_slot_in;
      hold_status_ff <= hold_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_slot = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

   `ASSERT_IMPL(a_no_overwrite, cmd.out_load, !rsp_valid_ff || !rsp_stall, "stalled result overwritten")
   `ASSERT_IMPL(a_head_range, head_ff[fsa_pkg::LINK_W-1], head_ff[fsa_pkg::SLOT_W-1:0] == '0, "list head beyond list end")
   `ASSERT_IMPL(a_walk_in_block, cmd.carve_step, carve_ptr_ff <= carve_last_ff, "carve walk left its block")

endmodule

// ===== hdl/fsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsa_ctrl
// Controller of the allocator: picks the operation of each accepted
// transaction and sequences pop, carve walk and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic                  req_free_is_null,
   input  fsa_pkg::fsa_stat_type stat,
   output fsa_pkg::fsa_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_POP   = 2'd1;
   localparam logic [1:0] ST_CARVE = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [fsa_pkg::OP_W-1:0]  op_sel;

   // Choose the operation from the request and the list state
   always_comb begin
      if (req_command == fsa_pkg::CMD_FREE) begin
         op_sel = req_free_is_null ? fsa_pkg::OP_NULL : fsa_pkg::OP_FREE;
      end else if (!stat.list_empty) begin
         op_sel = fsa_pkg::OP_POP;
      end else if (stat.can_carve) begin
         op_sel = fsa_pkg::OP_CARVE;
      end else begin
         op_sel = fsa_pkg::OP_OOM;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   // Sequence the datapath
   always_comb begin
      state_in       = state_ff;
      cmd.start      = 1'b0;
      cmd.op         = op_sel;
      cmd.pop_load   = 1'b0;
      cmd.carve_step = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_direct = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (op_sel == fsa_pkg::OP_POP) begin
                  state_in = ST_POP;
               end else if (op_sel == fsa_pkg::OP_CARVE) begin
                  state_in = ST_CARVE;
               end else if (stat.out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_direct = 1'b1;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_POP: begin
            cmd.pop_load = 1'b1;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_CARVE: begin
            cmd.carve_step = 1'b1;
            if (stat.carve_done) begin
               if (stat.out_free) begin
                  cmd.out_load = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMPL(a_accept_progress, req_valid && !req_stall, cmd.out_load || (state_in != ST_IDLE), "accepted transaction dropped")
   `ASSERT_NEXT(a_pop_one_cycle, state_ff == ST_POP, state_ff == ST_IDLE || state_ff == ST_HOLD, "pop did not finish in one cycle")
   `ASSERT_IMPL(a_start_idle, cmd.start, state_ff == ST_IDLE, "start issued outside idle")

endmodule

// ===== hdl/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// LIFO free-list allocator of fixed-size slots carved block by block from a
// pool of NUM_BLOCKS blocks of BLOCK_SLOTS slots.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_command, req_free_slot,
//                       req_free_is_null
//   rsp      out        rsp_valid, rsp_stall, rsp_alloc_slot, rsp_status
//
// Free, null free and out of memory finish on acceptance if output is free;
// a pop also passes the POP state, set by the registered link memory read.
// A carve walks the CARVE state, one link write per slot after the first.
// Reset needs no clearing pass: link entries are only read once written.
// A result waiting on rsp_stall holds the controller after one item.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [fsa_pkg::SLOT_W-1:0]    req_free_slot,
   input  logic                          req_free_is_null,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fsa_pkg::SLOT_W-1:0]    rsp_alloc_slot,
   output logic [fsa_pkg::STATUS_W-1:0]  rsp_status
);

   fsa_pkg::fsa_cmd_type  cmd;
   fsa_pkg::fsa_stat_type stat;

   // Controller
   fsa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_free_is_null (req_free_is_null),
      .stat             (stat),
      .cmd              (cmd)
   );

   // Datapath
   fsa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_free_slot  (req_free_slot),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_alloc_slot (rsp_alloc_slot),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== bench/fixed_slot_free_list_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_test
// Self-checking bench for the fixed-slot free-list allocator. A short scripted
// opening covers the first carve, pops, frees of slots never handed out, null
// frees and ignored fields on allocate. A random run of mixed grab and
// give-back bursts follows. A scripted close covers a slot that is freed
// twice. Each result is checked against a scripted value or an in-bench copy.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_test;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_AT        = 500;
   localparam int HOLD_LEN       = 300;
   localparam int DRAIN_CYCLES   = 600;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [fsa_pkg::SLOT_W-1:0]   slot;
      logic [fsa_pkg::STATUS_W-1:0] status;
   } outcome_type;

   typedef struct packed {
      logic                         command;
      logic [fsa_pkg::SLOT_W-1:0]   slot;
      logic                         is_null;
      logic                         typed;
      outcome_type                  want;
   } script_row_type;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic                         req_command      = fsa_pkg::CMD_ALLOC;
   logic [fsa_pkg::SLOT_W-1:0]   req_free_slot    = '0;
   logic                         req_free_is_null = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall        = 1'b0;
   logic [fsa_pkg::SLOT_W-1:0]   rsp_alloc_slot;
   logic [fsa_pkg::STATUS_W-1:0] rsp_status;

   // Allocator state mirrored in the bench
   logic [fsa_pkg::LINK_W-1:0]   link_of [fsa_pkg::SLOT_SPACE];
   logic [fsa_pkg::LINK_W-1:0]   list_head;
   logic [fsa_pkg::CARVED_W-1:0] carved_blocks;
   bit                           on_free_list [fsa_pkg::SLOT_SPACE];

   outcome_type                  outcomes_due [$];
   script_row_type               script_rows [$];
   logic [fsa_pkg::SLOT_W-1:0]   slots_in_use [$];

   int cycle_count  = 0;
   int idle_cycles  = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int n_granted    = 0;
   int n_oom        = 0;
   int n_freed      = 0;
   int n_null       = 0;

   fixed_slot_free_list_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_free_slot    (req_free_slot),
      .req_free_is_null (req_free_is_null),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_alloc_slot   (rsp_alloc_slot),
      .rsp_status       (rsp_status)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Count cycles, and cycles in which neither channel moves a transaction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("fixed_slot_free_list_allocator test failed");
      $finish;
   end

   // Mostly short gaps, a few long ones; none at all in the calm stretches
   function automatic int pick_gap();
      int roll;
      if ((cycle_count % 1000) < 150) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Apply one transaction to the mirrored allocator and return its result
   function automatic outcome_type allocate_or_free(logic command,
                                                    logic [fsa_pkg::SLOT_W-1:0] slot,
                                                    logic is_null);
      outcome_type got;
      int unsigned base;
      int          i;
      got.slot   = '0;
      got.status = fsa_pkg::STATUS_DONE;
      if (command == fsa_pkg::CMD_ALLOC) begin
         if (list_head < fsa_pkg::LIST_END) begin
            // pop the head of the list
            got.slot = list_head[fsa_pkg::SLOT_W-1:0];
            on_free_list[got.slot] = 1'b0;
            list_head = link_of[got.slot];
         end else if (carved_blocks < fsa_pkg::NUM_BLOCKS &&
                      (carved_blocks + 1) * fsa_pkg::BLOCK_SLOTS <= fsa_pkg::SLOT_SPACE) begin
            // carve the next block: hand out its first slot, chain the rest
            base = carved_blocks * fsa_pkg::BLOCK_SLOTS;
            for (i = 1; i < fsa_pkg::BLOCK_SLOTS; i++) begin
               link_of[base + i] = (i == fsa_pkg::BLOCK_SLOTS - 1)
                                   ? fsa_pkg::LINK_W'(fsa_pkg::LIST_END)
                                   : fsa_pkg::LINK_W'(base + i + 1);
               on_free_list[base + i] = 1'b1;
            end
            list_head     = fsa_pkg::LINK_W'(base + 1);
            carved_blocks = carved_blocks + 1'b1;
            got.slot      = fsa_pkg::SLOT_W'(base);
         end else begin
            got.status = fsa_pkg::STATUS_OOM;
         end
      end else if (is_null) begin
         got.status = fsa_pkg::STATUS_NULL;
      end else begin
         // push onto the head, unchecked
         link_of[slot]      = list_head;
         list_head          = {1'b0, slot};
         on_free_list[slot] = 1'b1;
      end
      return got;
   endfunction

   function automatic script_row_type script_row(logic command, int slot, logic is_null,
                                                 logic typed, int want_slot,
                                                 logic [fsa_pkg::STATUS_W-1:0] want_status);
      script_row_type r;
      r.command     = command;
      r.slot        = fsa_pkg::SLOT_W'(slot);
      r.is_null     = is_null;
      r.typed       = typed;
      r.want.slot   = fsa_pkg::SLOT_W'(want_slot);
      r.want.status = want_status;
      return r;
   endfunction

   // Offer one transaction, hold it until taken, then record its outcome
   task automatic issue_request(logic command, logic [fsa_pkg::SLOT_W-1:0] slot,
                                logic is_null, logic typed, outcome_type want);
      int          gap;
      outcome_type got;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= command;
      req_free_slot    <= slot;
      req_free_is_null <= is_null;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = allocate_or_free(command, slot, is_null);
      outcomes_due.push_back(typed ? want : got);
      if (command == fsa_pkg::CMD_ALLOC) begin
         if (got.status == fsa_pkg::STATUS_DONE) begin
            slots_in_use.push_back(got.slot);
            n_granted++;
         end else begin
            n_oom++;
         end
      end else if (is_null) begin
         n_null++;
      end else begin
         n_freed++;
      end
   endtask

   task automatic walk_script();
      script_row_type r;
      while (script_rows.size() != 0) begin
         r = script_rows.pop_front();
         issue_request(r.command, r.slot, r.is_null, r.typed, r.want);
      end
   endtask

   // Result side: check each transaction, stall at random, hold off once
   initial begin
      int          stall_left;
      bit          held;
      outcome_type due;
      stall_left = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (outcomes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: slot %0d status %0d",
                           rsp_alloc_slot, rsp_status);
            end else begin
               due = outcomes_due.pop_front();
               if (rsp_alloc_slot !== due.slot || rsp_status !== due.status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("result %0d: expected slot %0d status %0d, got %0d status %0d",
                              results_seen, due.slot, due.status,
                              rsp_alloc_slot, rsp_status);
               end
            end
         end
         if (!held && results_seen >= HOLD_AT) begin
            held       = 1'b1;
            stall_left = HOLD_LEN;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Request side
   initial begin
      int                         mode;
      int                         burst_left;
      int                         pick;
      int                         free_odds;
      int                         idx;
      int                         items;
      logic                       command;
      logic [fsa_pkg::SLOT_W-1:0] slot;
      logic                       is_null;
      outcome_type                none;

      none          = '0;
      list_head     = fsa_pkg::LINK_W'(fsa_pkg::LIST_END);
      carved_blocks = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Opening script: first carve, LIFO order, unchecked and null frees
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,    1'b0, 1'b1, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 4095, 1'b1, 1'b1, 1,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  4095, 1'b1, 1'b1, 0,
                                       fsa_pkg::STATUS_NULL));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  4095, 1'b0, 1'b1, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,    1'b0, 1'b1, 4095,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  0,    1'b0, 1'b1, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,    1'b0, 1'b1, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,    1'b0, 1'b1, 2,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  1,    1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  2,    1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,    1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,    1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  0,    1'b1, 1'b1, 0,
                                       fsa_pkg::STATUS_NULL));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  2730, 1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 1365, 1'b1, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  1365, 1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 2730, 1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  0,    1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,    1'b0, 1'b0, 0,
                                       fsa_pkg::STATUS_DONE));
      walk_script();

      // Random run: bursts that grab, give back or mix, with some noise.
      // A non-null free of a slot already on the list would close a loop in
      // it for good, so turn any such free into a null one.
      mode       = 0;
      burst_left = 0;
      for (items = 0; items < RANDOM_ITEMS; items++) begin
         if (burst_left == 0) begin
            mode       = $urandom_range(2);
            burst_left = $urandom_range(30, 1);
         end
         burst_left--;
         free_odds = (mode == 0) ? 15 : (mode == 1) ? 70 : 40;
         pick      = $urandom_range(99);
         slot      = fsa_pkg::SLOT_W'($urandom);
         command   = fsa_pkg::CMD_ALLOC;
         is_null   = 1'($urandom_range(1));
         if (pick < 10) begin
            command = 1'($urandom_range(1));
         end else if (pick < 17) begin
            command = fsa_pkg::CMD_FREE;
            is_null = 1'b1;
         end else if ($urandom_range(99) < free_odds && slots_in_use.size() > 0) begin
            idx     = $urandom_range(slots_in_use.size() - 1);
            slot    = slots_in_use[idx];
            slots_in_use.delete(idx);
            command = fsa_pkg::CMD_FREE;
            is_null = 1'b0;
         end
         if (command == fsa_pkg::CMD_FREE && !is_null && on_free_list[slot]) is_null = 1'b1;
         issue_request(command, slot, is_null, 1'b0, none);
      end

      // Closing script: a slot freed twice, which the list hands out again
      // and again
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  100, 1'b0, 1'b1, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  100, 1'b0, 1'b1, 0,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,   1'b0, 1'b1, 100,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_ALLOC, 0,   1'b1, 1'b1, 100,
                                       fsa_pkg::STATUS_DONE));
      script_rows.push_back(script_row(fsa_pkg::CMD_FREE,  100, 1'b1, 1'b1, 0,
                                       fsa_pkg::STATUS_NULL));
      walk_script();
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d grants, %0d out-of-memory refusals, %0d frees, %0d null frees",
               n_granted, n_oom, n_freed, n_null);
      $display("%0d of %0d blocks carved, %0d results checked, %0d mismatches",
               carved_blocks, fsa_pkg::NUM_BLOCKS, results_seen, mismatches);
      if (mismatches == 0 && outcomes_due.size() == 0) begin
         $display("fixed_slot_free_list_allocator test passed");
      end else begin
         $display("fixed_slot_free_list_allocator test failed");
      end
      $finish;
   end

endmodule
